### rtl/core/sorted_table_insert_search_top_defines.svh
// Assertion macros for the sorted table block.
`ifndef SORTED_TABLE_INSERT_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_INSERT_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define STIS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STIS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define STIS_ASSERT(lbl, clk, rst, prop, msg)
`define STIS_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

### rtl/core/stis_pkg.sv
`timescale 1ns / 1ps

package stis_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int KEY_W          = 32;
   localparam int VALUE_W        = 32;
   localparam int ENTRY_COUNT_W  = 7;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_FIND   = 1'b1;

   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_FOUND     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic       capture;      // latch the accepted item
      logic       ins_start;    // slot = count, read entry below it
      logic       shift;        // move read entry up one slot
      logic       place;        // write new entry at slot, bump count
      logic       find_start;   // open search window, read first probe
      logic       probe;        // narrow window, read next probe
      logic       finish;       // latch result status
      logic       take_rd_value;
      logic [1:0] status_code;
      logic       rsp_load;     // move result into output register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_find;
      logic full;
      logic empty;
      logic key_less;
      logic key_equal;
      logic slot_one;
      logic search_more;
      logic rsp_free;
   } dp_stat_type;

endpackage

### rtl/core/stis_req_if.sv
`timescale 1ns / 1ps

interface stis_req_if import stis_pkg::*;;
   logic               valid;
   logic               ready;
   logic               command;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output command, output key, output value, input ready);
   modport sink   (input valid, input command, input key, input value, output ready);
endinterface

### rtl/core/stis_rsp_if.sv
`timescale 1ns / 1ps

interface stis_rsp_if import stis_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [VALUE_W-1:0]       found_value;
   logic [ENTRY_COUNT_W-1:0] entry_count;

   modport source (output valid, output status, output found_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found_value, input entry_count,
                   output ready);
endinterface

### rtl/core/sorted_table_insert_search_top.sv
`timescale 1ns / 1ps

// Sorted key/value store with ordered insert and binary-search find.
// Up to CAPACITY entries are held in ascending key order in a single-port-write,
// registered-read memory. Keys compare unsigned, or as two's complement when
// the compare_signed bit (csr_wr_en / csr_wr_data) is set; change it only while
// idle. Command 0 inserts after every entry with a key not greater; command 1
// searches and returns the value of the first matching entry probed. Every item
// gives exactly one result with a status and the entry count after the command.
// Operation, one item at a time:
//   insert: each entry with a larger key is shifted up one slot, one entry per
//           cycle through the memory, before the new entry is placed
//   find:   binary search over the entries; each probe is one memory read
//   full insert or find on an empty store: status set without a memory read.
// A finished result waits in the output register; the next item is taken while
// it waits.

module sorted_table_insert_search_top import stis_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   stis_req_if.sink   req_chan,
   stis_rsp_if.source rsp_chan
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: decides insert/find steps from datapath status
   stis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // memory, count, search window and output register
   stis_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_command     (req_chan.command),
      .req_key         (req_chan.key),
      .req_value       (req_chan.value),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_found_value (rsp_chan.found_value),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule

### rtl/core/stis_ctrl.sv
`timescale 1ns / 1ps

module stis_ctrl import stis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_PROBE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            if (stat.is_find) begin
               if (stat.empty) begin
                  cmd.finish      = 1'b1;
                  cmd.status_code = ST_NOT_FOUND;
                  state_in        = S_DONE;
               end else begin
                  cmd.find_start = 1'b1;
                  state_in       = S_PROBE;
               end
            end else if (stat.full) begin
               cmd.finish      = 1'b1;
               cmd.status_code = ST_FULL;
               state_in        = S_DONE;
            end else begin
               cmd.ins_start = 1'b1;
               state_in      = stat.empty ? S_PLACE : S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (stat.key_less) begin
               cmd.shift = 1'b1;
               state_in  = stat.slot_one ? S_PLACE : S_SHIFT;
            end else begin
               cmd.place       = 1'b1;
               cmd.finish      = 1'b1;
               cmd.status_code = ST_INSERTED;
               state_in        = S_DONE;
            end
         end
         S_PLACE: begin
            cmd.place       = 1'b1;
            cmd.finish      = 1'b1;
            cmd.status_code = ST_INSERTED;
            state_in        = S_DONE;
         end
         S_PROBE: begin
            if (stat.key_equal) begin
               cmd.finish        = 1'b1;
               cmd.take_rd_value = 1'b1;
               cmd.status_code   = ST_FOUND;
               state_in          = S_DONE;
            end else begin
               cmd.probe = 1'b1;
               if (!stat.search_more) begin
                  cmd.finish      = 1'b1;
                  cmd.status_code = ST_NOT_FOUND;
                  state_in        = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/stis_dp.sv
`timescale 1ns / 1ps
`include "sorted_table_insert_search_top_defines.svh"

module stis_dp import stis_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data,
   input  logic                     req_command,
   input  logic [KEY_W-1:0]         req_key,
   input  logic [VALUE_W-1:0]       req_value,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [VALUE_W-1:0]       rsp_found_value,
   output logic [ENTRY_COUNT_W-1:0] rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic [KEY_W-1:0]   key_mem [0:CAPACITY-1];
   logic [VALUE_W-1:0] val_mem [0:CAPACITY-1];

   logic                     csr_signed_ff;
   logic                     item_cmd_ff;
   logic [KEY_W-1:0]         item_key_ff;
   logic [VALUE_W-1:0]       item_value_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [IDX_W-1:0]         slot_ff;
   logic [CNT_W-1:0]         lo_ff;
   logic [CNT_W-1:0]         hiex_ff;
   logic [IDX_W-1:0]         mid_ff;
   logic [KEY_W-1:0]         rd_key_ff;
   logic [VALUE_W-1:0]       rd_val_ff;
   logic [1:0]               res_status_ff;
   logic [VALUE_W-1:0]       res_value_ff;
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [VALUE_W-1:0]       rsp_value_ff;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff;

   logic [KEY_W-1:0]       ord_item;
   logic [KEY_W-1:0]       ord_rd;
   logic [CNT_W-1:0]       lo_in;
   logic [CNT_W-1:0]       hiex_in;
   logic [CNT_W:0]         mid_sum;
   logic [CNT_W-1:0]       cnt_m1;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       mid_in;
   logic [CNT_W+ENTRY_COUNT_W-1:0] cnt_ext;

   // flipping the sign bit turns a signed order into an unsigned one
   assign ord_item = item_key_ff ^ {csr_signed_ff, {(KEY_W-1){1'b0}}};
   assign ord_rd   = rd_key_ff   ^ {csr_signed_ff, {(KEY_W-1){1'b0}}};

   // search window is [lo, hiex); next window after this probe
   assign lo_in   = cmd.find_start ? '0 :
                    (stat.key_less ? lo_ff : CNT_W'(mid_ff) + CNT_W'(1));
   assign hiex_in = cmd.find_start ? count_ff :
                    (stat.key_less ? CNT_W'(mid_ff) : hiex_ff);
   assign mid_sum = {1'b0, lo_in} + {1'b0, hiex_in} - (CNT_W+1)'(1);
   assign mid_in  = IDX_W'(mid_sum >> 1);
   assign cnt_m1  = count_ff - CNT_W'(1);

   always_comb begin
      rd_addr = mid_in;
      if (cmd.ins_start) begin
         rd_addr = IDX_W'(cnt_m1);
      end else if (cmd.shift) begin
         rd_addr = slot_ff - IDX_W'(2);
      end
   end

   assign stat.is_find     = (item_cmd_ff == CMD_FIND);
   assign stat.full        = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty       = (count_ff == '0);
   assign stat.key_less    = (ord_item < ord_rd);
   assign stat.key_equal   = (item_key_ff == rd_key_ff);
   assign stat.slot_one    = (slot_ff == IDX_W'(1));
   assign stat.search_more = (lo_in < hiex_in);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   // entry memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         key_mem[slot_ff] <= rd_key_ff;
         val_mem[slot_ff] <= rd_val_ff;
      end else if (cmd.place) begin
         key_mem[slot_ff] <= item_key_ff;
         val_mem[slot_ff] <= item_value_ff;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff   <= req_command;
         item_key_ff   <= req_key;
         item_value_ff <= req_value;
      end
      if (cmd.ins_start) begin
         slot_ff <= IDX_W'(count_ff);
      end else if (cmd.shift) begin
         slot_ff <= slot_ff - IDX_W'(1);
      end
      if (cmd.find_start || cmd.probe) begin
         lo_ff   <= lo_in;
         hiex_ff <= hiex_in;
         mid_ff  <= mid_in;
      end
      if (cmd.finish) begin
         res_status_ff <= cmd.status_code;
         res_value_ff  <= cmd.take_rd_value ? rd_val_ff : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_count_ff  <= cnt_ext[ENTRY_COUNT_W-1:0];
      end
   end

   assign cnt_ext = (CNT_W+ENTRY_COUNT_W)'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_signed_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_signed_ff <= csr_wr_data;
         end
         if (cmd.place) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   `STIS_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(CAPACITY), "count over capacity")
   `STIS_ASSERT_NEVER(a_shift_slot, clock, reset, cmd.shift && slot_ff == '0, "shift from slot zero")
   `STIS_ASSERT(a_place_count, clock, reset, cmd.place |=> count_ff == $past(count_ff) + CNT_W'(1), "count not bumped")
   `STIS_ASSERT_NEVER(a_place_full, clock, reset, cmd.place && stat.full, "write into full store")

endmodule
